>>> src/hvdr_pkg.sv
// Shared types and constants for the high-voltage supply DAC regulator.
package hvdr_pkg;

  // Input request and result payloads.
  typedef struct packed {
    logic [9:0] target_voltage;
    logic [9:0] measured_voltage;
  } req_t;

  typedef struct packed {
    logic [15:0] dac_code;
    logic [10:0] ramped_setpoint;
    logic [9:0]  correction_value;
  } rsp_t;

  // Work item handed from the front end to the back end.
  typedef struct packed {
    logic [10:0] setpoint;
    logic [9:0]  correction;
  } work_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic       polarity_inverted;
    logic [3:0] ramp_step;
  } cfg_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCALE,
    BK_CLAMP,
    BK_MAP,
    BK_OUT
  } bk_state_t;

  // Register selects, taken from paddr bit 2.
  localparam logic RegPolarity = 1'b0;
  localparam logic RegRampStep = 1'b1;

  localparam int AddrWidth = 3;

  // Reset values of the configuration registers.
  localparam logic       PolarityReset = 1'b0;
  localparam logic [3:0] RampStepReset = 4'd2;

  // Integrator limits.
  localparam logic [9:0] CorrMax   = 10'h3FF;
  localparam logic [9:0] CorrReset = 10'h200;

  // Scaling constants.
  localparam logic [13:0] ScaleBase = 14'h1E00;
  localparam logic [22:0] RoundHalf = 23'd128;
  localparam logic [9:0]  ScaledMax = 10'd955;

  // DAC mapping: code = scaled * gain / 2^DacShift.
  localparam int          DacGainInt = 65535 * 16384 / 955;
  localparam logic [20:0] DacGain    = 21'(DacGainInt);
  localparam int          DacShift   = 14;

  // Front-to-back queue geometry.
  localparam int QueueDepth = 2;
  localparam int QPtrWidth  = $clog2(QueueDepth);
  localparam int QCntWidth  = $clog2(QueueDepth + 1);

endpackage

>>> src/hvdr_front.sv
// Front end: accepts requests and updates the integrator and ramped setpoint.
module hvdr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hvdr_pkg::req_t   req,
  input  logic [3:0]       ramp_step,
  input  logic             queue_full,
  output logic             work_push,
  output hvdr_pkg::work_t  work
);

  logic [9:0]  correction;
  logic [9:0]  correction_next;
  logic [10:0] setpoint;
  logic [10:0] setpoint_next;
  logic [11:0] ramp_sum;
  logic [10:0] target_ext;
  logic        accept;

  assign accept     = push && !queue_full;
  assign target_ext = {1'b0, req.target_voltage};
  assign ramp_sum   = {1'b0, setpoint} + {8'b0, ramp_step};

  // Integrator moves one count toward the request and saturates at both ends.
  always_comb begin
    correction_next = correction;
    if (req.target_voltage > req.measured_voltage) begin
      if (correction != hvdr_pkg::CorrMax) begin
        correction_next = correction + 10'd1;
      end
    end else if (req.target_voltage < req.measured_voltage) begin
      if (correction != 10'd0) begin
        correction_next = correction - 10'd1;
      end
    end
  end

  // Setpoint climbs by the ramp step and drops to a lower request at once.
  always_comb begin
    setpoint_next = setpoint;
    if (target_ext > setpoint) begin
      setpoint_next = ramp_sum[10:0];
    end else if (target_ext < setpoint) begin
      setpoint_next = target_ext;
    end
  end

  // State registers advance only on an accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      correction <= hvdr_pkg::CorrReset;
      setpoint   <= 11'd0;
    end else if (accept) begin
      correction <= correction_next;
      setpoint   <= setpoint_next;
    end
  end

  assign work_push       = accept;
  assign work.setpoint   = setpoint_next;
  assign work.correction = correction_next;

endmodule

>>> src/hvdr_queue.sv
// Two-entry queue that decouples the front end from the back end.
module hvdr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hvdr_pkg::work_t  wdata,
  output logic             full,
  input  logic             pop,
  output hvdr_pkg::work_t  rdata,
  output logic             empty
);

  hvdr_pkg::work_t                   entries [hvdr_pkg::QueueDepth];
  logic [hvdr_pkg::QPtrWidth-1:0]    wr_ptr;
  logic [hvdr_pkg::QPtrWidth-1:0]    rd_ptr;
  logic [hvdr_pkg::QCntWidth-1:0]    count;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (count == hvdr_pkg::QCntWidth'(hvdr_pkg::QueueDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == hvdr_pkg::QPtrWidth'(hvdr_pkg::QueueDepth - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == hvdr_pkg::QPtrWidth'(hvdr_pkg::QueueDepth - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/hvdr_back.sv
// Back end: scales the setpoint, clamps it and maps it onto the DAC code.
module hvdr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             polarity_inverted,
  input  logic             work_empty,
  input  hvdr_pkg::work_t  work,
  output logic             work_pop,
  output logic             empty,
  input  logic             pop,
  output hvdr_pkg::rsp_t   rsp
);

  hvdr_pkg::bk_state_t state;
  hvdr_pkg::bk_state_t state_next;

  logic [10:0]  setpoint;
  logic [9:0]   correction;
  logic [13:0]  gain_sum;
  logic [10:0]  gain;
  logic [21:0]  scale_prod;
  logic [22:0]  rounded;
  logic [9:0]   scaled;
  logic [30:0]  map_prod;
  logic [15:0]  code;
  logic         out_valid;
  logic         out_load;
  hvdr_pkg::rsp_t out_reg;

  // Gain is (ScaleBase + correction) >> 3.
  assign gain_sum = hvdr_pkg::ScaleBase + {4'b0, correction};
  assign gain     = gain_sum[13:3];
  assign rounded  = {1'b0, scale_prod} + hvdr_pkg::RoundHalf;
  assign code     = map_prod[hvdr_pkg::DacShift+15:hvdr_pkg::DacShift];

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hvdr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    work_pop   = 1'b0;
    out_load   = 1'b0;
    case (state)
      hvdr_pkg::BK_IDLE: begin
        if (!work_empty) begin
          work_pop   = 1'b1;
          state_next = hvdr_pkg::BK_SCALE;
        end
      end
      hvdr_pkg::BK_SCALE: state_next = hvdr_pkg::BK_CLAMP;
      hvdr_pkg::BK_CLAMP: state_next = hvdr_pkg::BK_MAP;
      hvdr_pkg::BK_MAP:   state_next = hvdr_pkg::BK_OUT;
      hvdr_pkg::BK_OUT: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = hvdr_pkg::BK_IDLE;
        end
      end
      default: state_next = hvdr_pkg::BK_IDLE;
    endcase
  end

  // Datapath registers, one operation per state.
  always_ff @(posedge clk) begin
    case (state)
      hvdr_pkg::BK_IDLE: begin
        if (work_pop) begin
          setpoint   <= work.setpoint;
          correction <= work.correction;
        end
      end
      hvdr_pkg::BK_SCALE: scale_prod <= gain * setpoint;
      hvdr_pkg::BK_CLAMP: begin
        if (rounded[22:10] > {3'b0, hvdr_pkg::ScaledMax}) begin
          scaled <= hvdr_pkg::ScaledMax;
        end else begin
          scaled <= rounded[19:10];
        end
      end
      hvdr_pkg::BK_MAP: map_prod <= scaled * hvdr_pkg::DacGain;
      default: ;
    endcase
  end

  // Result register holds one finished result until it is taken.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg.dac_code         <= polarity_inverted ? code : ~code;
      out_reg.ramped_setpoint  <= setpoint;
      out_reg.correction_value <= correction;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;
  assign rsp   = out_reg;

endmodule

>>> src/hv_supply_dac_regulator_unit.sv
// Top level of the high-voltage supply DAC regulator with its register port.
//
// Each request is one regulation tick and yields exactly one result. The front
// end takes a request whenever its two-entry queue has room, updating the
// correction integrator and the ramped setpoint at once. The back end sequencer
// then handles one tick at a time (load, scale multiply, round and clamp, DAC
// mapping multiply, result write), taking the next tick only after the result
// write, which waits until any earlier result has been taken. A finished result
// waits in an output register while the front end keeps accepting requests.
// Registers: polarity at byte address 0, ramp step at byte address 4.
module hv_supply_dac_regulator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  hvdr_pkg::req_t                req,
  output logic                          empty,
  input  logic                          pop,
  output hvdr_pkg::rsp_t                rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hvdr_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  hvdr_pkg::cfg_t  cfg;
  hvdr_pkg::work_t work_in;
  hvdr_pkg::work_t work_out;
  logic            work_push;
  logic            work_pop;
  logic            work_full;
  logic            work_empty;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polarity_inverted <= hvdr_pkg::PolarityReset;
      cfg.ramp_step         <= hvdr_pkg::RampStepReset;
    end else if (cfg_write) begin
      case (paddr[2])
        hvdr_pkg::RegPolarity: cfg.polarity_inverted <= pwdata[0];
        hvdr_pkg::RegRampStep: cfg.ramp_step         <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      hvdr_pkg::RegPolarity: prdata = {31'b0, cfg.polarity_inverted};
      hvdr_pkg::RegRampStep: prdata = {28'b0, cfg.ramp_step};
      default:               prdata = 32'b0;
    endcase
  end

  hvdr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .req        (req),
    .ramp_step  (cfg.ramp_step),
    .queue_full (work_full),
    .work_push  (work_push),
    .work       (work_in)
  );

  hvdr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (work_push),
    .wdata (work_in),
    .full  (work_full),
    .pop   (work_pop),
    .rdata (work_out),
    .empty (work_empty)
  );

  hvdr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .polarity_inverted (cfg.polarity_inverted),
    .work_empty        (work_empty),
    .work              (work_out),
    .work_pop          (work_pop),
    .empty             (empty),
    .pop               (pop),
    .rsp               (rsp)
  );

  assign full = work_full;

endmodule

>>> src/hvdr_checker.sv
// Port-level checks for the high-voltage supply DAC regulator.
module hvdr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input hvdr_pkg::rsp_t                 rsp,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [hvdr_pkg::AddrWidth-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready
);

  // Reset leaves no result pending and room for a request.
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue state not cleared by reset");

  // A result that is not taken stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(rsp))
    else $error("pending result changed before it was taken");

  // The setpoint can pass a request by less than one ramp step only, so it stays at or below 1037.
  a_setpoint_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> rsp.ramped_setpoint <= 11'd1037)
    else $error("ramped setpoint out of range");

  // A polarity write reads back on the next cycle.
  a_polarity_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 (!paddr[2])
    |-> prdata[0] == $past(pwdata[0]))
    else $error("polarity register did not take the written value");

endmodule

bind hv_supply_dac_regulator_unit hvdr_checker u_checker (.*);

>>> verif/hv_supply_dac_regulator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the high-voltage supply DAC regulator top level.
module hv_supply_dac_regulator_unit_tb;

  localparam int IdlePct = 31;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 20;
  localparam int PhaseCount = 10;
  localparam int PhaseTicks = 105;
  localparam int MaxPrinted = 40;

  // Regulator arithmetic, kept independent of the design's constants.
  localparam logic [9:0] IntegTop = 10'h3FF;
  localparam logic [9:0] IntegStart = 10'h200;
  localparam int unsigned GainBase = 7680;
  localparam int unsigned RoundBias = 128;
  localparam int unsigned ScaleCeiling = 955;
  localparam longint unsigned MapGain = 64'd65535 * 64'd16384 / 64'd955;

  typedef enum int {DriveUp, DriveDown, DriveMixed} drive_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  hvdr_pkg::req_t req;
  logic empty;
  logic pop;
  hvdr_pkg::rsp_t rsp;
  logic psel;
  logic penable;
  logic pwrite;
  logic [hvdr_pkg::AddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Predictor state and configuration.
  logic [9:0] integ_model;
  logic [10:0] setpoint_model;
  logic polarity_model;
  logic [3:0] step_model;

  hvdr_pkg::rsp_t pending_results[$];
  int mismatches;
  int quiet_cycles;
  bit steady;

  hv_supply_dac_regulator_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // One regulation tick: integrator first, then setpoint, then DAC code.
  function automatic hvdr_pkg::rsp_t regulate_tick(input hvdr_pkg::req_t r);
    int unsigned gain;
    int unsigned scaled;
    longint unsigned mapped;
    logic [15:0] code;
    hvdr_pkg::rsp_t res;
    if (r.target_voltage > r.measured_voltage) begin
      if (integ_model != IntegTop) integ_model = integ_model + 10'd1;
    end else if (r.target_voltage < r.measured_voltage) begin
      if (integ_model != 10'd0) integ_model = integ_model - 10'd1;
    end
    if ({1'b0, r.target_voltage} > setpoint_model) begin
      setpoint_model = setpoint_model + 11'(step_model);
    end else if ({1'b0, r.target_voltage} < setpoint_model) begin
      setpoint_model = {1'b0, r.target_voltage};
    end
    gain = (GainBase + int'(integ_model)) >> 3;
    scaled = (gain * int'(setpoint_model) + RoundBias) >> 10;
    if (scaled > ScaleCeiling) scaled = ScaleCeiling;
    mapped = longint'(scaled) * MapGain / 64'd16384;
    code = ~mapped[15:0];
    if (polarity_model) code = ~code;
    res.dac_code = code;
    res.ramped_setpoint = setpoint_model;
    res.correction_value = integ_model;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Send one request, idling at random first, and record its prediction.
  task automatic apply_tick(input logic [9:0] target, input logic [9:0] measured);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    req.target_voltage = target;
    req.measured_voltage = measured;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(regulate_tick(req));
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic wait_drain();
    @(negedge clk);
    push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = hvdr_pkg::AddrWidth'({sel, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == hvdr_pkg::RegPolarity) polarity_model = value[0];
    else step_model = value[3:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_reg(input logic sel, input logic [31:0] want);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = hvdr_pkg::AddrWidth'({sel, 2'b00});
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      report_mismatch($sformatf("register %0d read %0h expected %0h", sel, prdata, want));
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Registers change only once the block has gone idle.
  task automatic configure(input logic polarity, input logic [3:0] step);
    wait_drain();
    write_reg(hvdr_pkg::RegPolarity, {31'd0, polarity});
    write_reg(hvdr_pkg::RegRampStep, {28'd0, step});
    check_reg(hvdr_pkg::RegPolarity, {31'd0, polarity});
    check_reg(hvdr_pkg::RegRampStep, {28'd0, step});
  endtask

  function automatic logic [9:0] pick_measured(input logic [9:0] target, input drive_t drive);
    int roll;
    roll = $urandom_range(0, 99);
    if (drive == DriveMixed) return 10'($urandom_range(0, 1023));
    if (roll >= 97) return target;
    // Most ticks push the integrator the chosen way; a few go the other way.
    if ((drive == DriveUp) == (roll < 94)) begin
      if (target == 10'd0) return target;
      return 10'($urandom_range(0, int'(target) - 1));
    end
    if (target == IntegTop) return target;
    return 10'($urandom_range(int'(target) + 1, 1023));
  endfunction

  task automatic test_register_reset();
    check_reg(hvdr_pkg::RegPolarity, {31'd0, hvdr_pkg::PolarityReset});
    check_reg(hvdr_pkg::RegRampStep, {28'd0, hvdr_pkg::RampStepReset});
  endtask

  task automatic test_field_extremes();
    apply_tick(10'd0, 10'd0);
    apply_tick(10'h3FF, 10'd0);
    apply_tick(10'h3FF, 10'd0);
    apply_tick(10'd0, 10'h3FF);
    apply_tick(10'h3FF, 10'h3FF);
    apply_tick(10'h2AA, 10'h155);
    apply_tick(10'h155, 10'h2AA);
    apply_tick(10'd1, 10'd0);
    apply_tick(10'd0, 10'd1);
  endtask

  // A large step passes a low request, then snaps back to it.
  task automatic test_ramp_overshoot();
    configure(1'b1, 4'd15);
    repeat (3) apply_tick(10'd5, 10'd5);
    repeat (3) apply_tick(10'd30, 10'd12);
  endtask

  // With a zero step the setpoint cannot rise but still drops.
  task automatic test_ramp_step_zero();
    configure(1'b0, 4'd0);
    repeat (2) apply_tick(10'd600, 10'd700);
    apply_tick(10'd3, 10'd3);
    apply_tick(10'd3, 10'd900);
    configure(1'b0, 4'd1);
    repeat (2) apply_tick(10'd8, 10'd2);
  endtask

  // Phases of held requests with random measurements; early phases drive the
  // integrator into its upper limit, later ones pull it back down.
  task automatic test_random_regulation();
    logic [3:0] step;
    logic [9:0] target;
    drive_t drive;
    int sent;
    int run;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0, 2: step = 4'd15;
        1: step = 4'd1;
        default: step = 4'($urandom_range(1, 15));
      endcase
      configure(p[0], step);
      steady = (p == 3);
      if (p < 6) drive = DriveUp;
      else if (p[0]) drive = DriveMixed;
      else drive = DriveDown;
      // A long climb toward a high request reaches the clamp and overshoot.
      target = ($urandom_range(0, 3) == 0) ? 10'h3FF : 10'($urandom_range(900, 1023));
      run = $urandom_range(40, 80);
      sent = 0;
      while (sent < PhaseTicks) begin
        if (run == 0) begin
          if ($urandom_range(0, 99) < 20) begin
            apply_tick(10'($urandom), 10'($urandom));
            sent++;
            continue;
          end
          case ($urandom_range(0, 9))
            0: target = 10'd0;
            1: target = 10'h3FF;
            default: target = 10'($urandom);
          endcase
          run = $urandom_range(1, 30);
        end
        apply_tick(target, pick_measured(target, drive));
        sent++;
        run--;
        if (p == 5 && sent == PhaseTicks / 2) wait_drain();
      end
    end
    steady = 1'b0;
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    hvdr_pkg::rsp_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (rsp.dac_code !== want.dac_code) begin
          report_mismatch($sformatf("dac_code %0h expected %0h", rsp.dac_code, want.dac_code));
        end
        if (rsp.ramped_setpoint !== want.ramped_setpoint) begin
          report_mismatch($sformatf("ramped_setpoint %0d expected %0d",
                                    rsp.ramped_setpoint, want.ramped_setpoint));
        end
        if (rsp.correction_value !== want.correction_value) begin
          report_mismatch($sformatf("correction_value %0d expected %0d",
                                    rsp.correction_value, want.correction_value));
        end
      end
    end
  end

  // The receiver stalls at random outside the steady stretch.
  always @(negedge clk) begin
    pop = steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // End the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    integ_model = IntegStart;
    setpoint_model = 11'd0;
    polarity_model = hvdr_pkg::PolarityReset;
    step_model = hvdr_pkg::RampStepReset;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_reset();
    test_field_extremes();
    test_ramp_overshoot();
    test_ramp_step_zero();
    test_random_regulation();

    wait_drain();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
